/* design/assert_macros.svh */
// Assertion macros for the design files, used by the controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Plain condition checked at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

`endif

/* design/mhs_pkg.sv */
// Package: constants, codes and controller/datapath interface types.
package mhs_pkg;

  localparam logic [31:0] GOLDEN    = 32'h9e3779b9;
  localparam logic [31:0] SAT_LIMIT = 32'd1000000;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  // Effective strategy codes.
  localparam logic [1:0] STRAT_HASH  = 2'd0;
  localparam logic [1:0] STRAT_LQ    = 2'd1;
  localparam logic [1:0] STRAT_HASHW = 2'd2;
  localparam logic [1:0] STRAT_RR    = 2'd3;

  // Strategy register values.
  localparam logic [2:0] SREG_RR_TOR = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_STRATEGY = 2'd0;
  localparam logic [1:0] CFG_COMPARE  = 2'd1;
  localparam logic [1:0] CFG_SALT     = 2'd2;
  localparam logic [1:0] CFG_TOR      = 2'd3;

  // Modulo unit dividend sources.
  localparam logic [1:0] MOD_HASH    = 2'd0;
  localparam logic [1:0] MOD_CURSOR  = 2'd1;
  localparam logic [1:0] MOD_RND     = 2'd2;
  localparam logic [1:0] MOD_RND_SHR = 2'd3;

  typedef struct packed {
    logic       load;
    logic       upd;
    logic       hash_start;
    logic       mod_start;
    logic [1:0] mod_src;
    logic       mod_by_ties;
    logic       scan_start;
    logic       sel_start;
    logic       sel_ties;
    logic       cursor_inc;
    logic       out_load;
    logic       out_found;
  } cmd_t;

  typedef struct packed {
    logic       n_zero;
    logic       n_one;
    logic [1:0] strat;
    logic       rnd0;
    logic       hash_busy;
    logic       mod_busy;
    logic       scan_busy;
    logic       chosen_worst;
    logic       out_free;
  } sts_t;

  function automatic logic [31:0] metric(input logic [31:0] q, input logic sat);
    metric = (sat && q > SAT_LIMIT) ? SAT_LIMIT : q;
  endfunction

endpackage

/* design/mhs_datapath.sv */
// Datapath: registers, hash mixer, serial modulo, candidate scanner, output register.
module mhs_datapath #(
  parameter int NUM_PORTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  mhs_pkg::cmd_t     cmd,
  output mhs_pkg::sts_t     sts,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [30:0]       cfg_data,
  input  logic              command,
  input  logic [31:0]       src_addr,
  input  logic [31:0]       dst_addr,
  input  logic [7:0]        protocol,
  input  logic [15:0]       src_port,
  input  logic [15:0]       dst_port,
  input  logic [15:0]       candidate_mask,
  input  logic [15:0]       random_value,
  input  logic [3:0]        port_number,
  input  logic [31:0]       queue_bytes,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        chosen_port,
  output logic              route_found
);
  localparam int CAND = (NUM_PORTS < 16) ? NUM_PORTS : 16;
  localparam int PW   = $clog2(CAND);

  // configuration
  logic [2:0]  strategy;
  logic        compare_mode;
  logic [30:0] hash_salt;
  logic        is_top_of_rack;

  // item
  logic [31:0]     src_r, dst_r;
  logic [7:0]      proto_r;
  logic [15:0]     sport_r, dport_r, rnd_r;
  logic [CAND-1:0] cmask;
  logic [4:0]      n_r;
  logic [4:0]      n_in;

  // state
  logic [31:0] qb [CAND];
  logic [31:0] cursor;

  // hash
  logic [31:0] hx, hy, hz;
  logic [3:0]  hstep;
  logic        hash_busy;
  logic [31:0] ha, hb;

  // modulo
  logic [31:0] mdvd;
  logic [3:0]  mrem;
  logic [4:0]  mdiv, mcnt;
  logic        mod_busy;
  logic [4:0]  mt;
  logic [31:0] msrc;

  // scanner
  logic [PW-1:0] sidx;
  logic          scan_busy, sel_mode, sel_ties, first;
  logic [31:0]   best, worst;
  logic [4:0]    tcnt;
  logic [3:0]    hits;
  logic [PW-1:0] port;
  logic [31:0]   m_scan, m_port;
  logic          sel_hit;

  always_comb begin
    n_in = '0;
    for (int p = 0; p < CAND; p++) n_in = n_in + 5'(candidate_mask[p]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strategy       <= '0;
      compare_mode   <= 1'b0;
      hash_salt      <= '0;
      is_top_of_rack <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mhs_pkg::CFG_STRATEGY: strategy       <= cfg_data[2:0];
        mhs_pkg::CFG_COMPARE:  compare_mode   <= cfg_data[0];
        mhs_pkg::CFG_SALT:     hash_salt      <= cfg_data;
        mhs_pkg::CFG_TOR:      is_top_of_rack <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      src_r   <= src_addr;
      dst_r   <= dst_addr;
      proto_r <= protocol;
      sport_r <= src_port;
      dport_r <= dst_port;
      rnd_r   <= random_value;
      cmask   <= candidate_mask[CAND-1:0];
      n_r     <= n_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CAND; i++) qb[i] <= '0;
      cursor <= '0;
    end else begin
      if (cmd.upd && command && (32'(port_number) < 32'(CAND)))
        qb[port_number[PW-1:0]] <= queue_bytes;
      if (cmd.cursor_inc) cursor <= cursor + 32'd1;
    end
  end

  // hash: one mix step per cycle
  assign ha = src_r ^ (dst_r << 1) ^ ({24'd0, proto_r} << 16);
  assign hb = (proto_r == mhs_pkg::PROTO_TCP || proto_r == mhs_pkg::PROTO_UDP) ?
              {sport_r, dport_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_busy <= 1'b0;
      hstep     <= '0;
    end else if (cmd.hash_start) begin
      hx        <= ha + mhs_pkg::GOLDEN;
      hy        <= {1'b0, hash_salt} + mhs_pkg::GOLDEN;
      hz        <= hb;
      hstep     <= '0;
      hash_busy <= 1'b1;
    end else if (hash_busy) begin
      case (hstep)
        4'd0: hx <= (hx - hy - hz) ^ (hz >> 13);
        4'd1: hy <= (hy - hz - hx) ^ (hx << 8);
        4'd2: hz <= (hz - hx - hy) ^ (hy >> 13);
        4'd3: hx <= (hx - hy - hz) ^ (hz >> 12);
        4'd4: hy <= (hy - hz - hx) ^ (hx << 16);
        4'd5: hz <= (hz - hx - hy) ^ (hy >> 5);
        4'd6: hx <= (hx - hy - hz) ^ (hz >> 3);
        4'd7: hy <= (hy - hz - hx) ^ (hx << 10);
        4'd8: hz <= (hz - hx - hy) ^ (hy >> 15);
        default: ;
      endcase
      hstep <= hstep + 4'd1;
      if (hstep == 4'd8) hash_busy <= 1'b0;
    end
  end

  // modulo: restoring, one dividend bit per cycle
  always_comb begin
    case (cmd.mod_src)
      mhs_pkg::MOD_HASH:    msrc = hz;
      mhs_pkg::MOD_CURSOR:  msrc = cursor;
      mhs_pkg::MOD_RND:     msrc = {16'd0, rnd_r};
      mhs_pkg::MOD_RND_SHR: msrc = {17'd0, rnd_r[15:1]};
      default:              msrc = hz;
    endcase
  end

  assign mt = {mrem, mdvd[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_busy <= 1'b0;
      mcnt     <= '0;
    end else if (cmd.mod_start) begin
      mdvd     <= msrc;
      mrem     <= '0;
      mdiv     <= cmd.mod_by_ties ? tcnt : n_r;
      mcnt     <= '0;
      mod_busy <= 1'b1;
    end else if (mod_busy) begin
      mrem <= (mt >= mdiv) ? 4'(mt - mdiv) : mt[3:0];
      mdvd <= mdvd << 1;
      mcnt <= mcnt + 5'd1;
      if (mcnt == 5'd31) mod_busy <= 1'b0;
    end
  end

  // scanner: metric pass or k-th selection
  assign m_scan  = mhs_pkg::metric(qb[sidx], compare_mode);
  assign m_port  = mhs_pkg::metric(qb[port], compare_mode);
  assign sel_hit = cmask[sidx] && (!sel_ties || m_scan == best) && (hits == mrem);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_busy <= 1'b0;
      sel_mode  <= 1'b0;
      sidx      <= '0;
    end else if (cmd.scan_start || cmd.sel_start) begin
      scan_busy <= 1'b1;
      sel_mode  <= cmd.sel_start;
      sel_ties  <= cmd.sel_ties;
      sidx      <= '0;
      hits      <= '0;
      first     <= cmd.scan_start;
      if (cmd.scan_start) tcnt <= '0;
    end else if (scan_busy) begin
      sidx <= sidx + PW'(1);
      if (sidx == PW'(CAND - 1) || (sel_mode && sel_hit)) scan_busy <= 1'b0;
      if (sel_mode) begin
        if (sel_hit) begin
          port <= sidx;
        end else if (cmask[sidx] && (!sel_ties || m_scan == best)) begin
          hits <= hits + 4'd1;
        end
      end else if (cmask[sidx]) begin
        first <= 1'b0;
        if (first || m_scan < best) begin
          best <= m_scan;
          tcnt <= 5'd1;
        end else if (m_scan == best) begin
          tcnt <= tcnt + 5'd1;
        end
        if (first || m_scan > worst) worst <= m_scan;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid   <= 1'b1;
      chosen_port <= cmd.out_found ? 4'(port) : 4'd0;
      route_found <= cmd.out_found;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    sts.n_zero       = (n_r == 5'd0);
    sts.n_one        = (n_r == 5'd1);
    if (strategy == mhs_pkg::SREG_RR_TOR)
      sts.strat = is_top_of_rack ? mhs_pkg::STRAT_RR : mhs_pkg::STRAT_HASH;
    else if (strategy > mhs_pkg::SREG_RR_TOR)
      sts.strat = mhs_pkg::STRAT_HASH;
    else
      sts.strat = strategy[1:0];
    sts.rnd0         = rnd_r[0];
    sts.hash_busy    = hash_busy;
    sts.mod_busy     = mod_busy;
    sts.scan_busy    = scan_busy;
    sts.chosen_worst = (m_port == worst);
    sts.out_free     = !out_valid || !out_stall;
  end

endmodule

/* design/mhs_ctrl.sv */
// Controller: sequences hash, modulo and scan passes for each item.
`include "assert_macros.svh"
module mhs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          command,
  input  mhs_pkg::sts_t sts,
  output mhs_pkg::cmd_t cmd
);
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_START = 4'd1;
  localparam logic [3:0] ST_HASH  = 4'd2;
  localparam logic [3:0] ST_MOD   = 4'd3;
  localparam logic [3:0] ST_SEL   = 4'd4;
  localparam logic [3:0] ST_SCAN  = 4'd5;
  localparam logic [3:0] ST_CHKW  = 4'd6;
  localparam logic [3:0] ST_DONE  = 4'd7;

  logic [3:0] state, state_next;
  logic       ties, ties_next;
  logic       phase2, phase2_next;
  logic       found, found_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next  = state;
    ties_next   = ties;
    phase2_next = phase2;
    found_next  = found;
    cmd         = '0;
    cmd.sel_ties  = ties;
    cmd.out_found = found;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.upd  = command;
          if (!command) state_next = ST_START;
        end
      end
      ST_START: begin
        ties_next   = 1'b0;
        phase2_next = 1'b0;
        found_next  = !sts.n_zero;
        if (sts.n_zero) begin
          state_next = ST_DONE;
        end else if (sts.n_one) begin
          cmd.mod_start = 1'b1;
          cmd.mod_src   = mhs_pkg::MOD_RND;
          state_next    = ST_MOD;
        end else begin
          case (sts.strat)
            mhs_pkg::STRAT_LQ: begin
              cmd.scan_start = 1'b1;
              state_next     = ST_SCAN;
            end
            mhs_pkg::STRAT_RR: begin
              cmd.mod_start  = 1'b1;
              cmd.mod_src    = mhs_pkg::MOD_CURSOR;
              cmd.cursor_inc = 1'b1;
              state_next     = ST_MOD;
            end
            default: begin
              cmd.hash_start = 1'b1;
              state_next     = ST_HASH;
            end
          endcase
        end
      end
      ST_HASH: begin
        if (!sts.hash_busy) begin
          cmd.mod_start = 1'b1;
          cmd.mod_src   = mhs_pkg::MOD_HASH;
          state_next    = ST_MOD;
        end
      end
      ST_MOD: begin
        if (!sts.mod_busy) begin
          cmd.sel_start = 1'b1;
          state_next    = ST_SEL;
        end
      end
      ST_SEL: begin
        if (!sts.scan_busy) begin
          // hashed pick may get a worst-path replacement on a coin flip
          if (sts.strat == mhs_pkg::STRAT_HASHW && !sts.n_one && sts.rnd0 && !phase2) begin
            cmd.scan_start = 1'b1;
            state_next     = ST_SCAN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (!sts.scan_busy) begin
          if (sts.strat == mhs_pkg::STRAT_LQ) begin
            cmd.mod_start   = 1'b1;
            cmd.mod_src     = mhs_pkg::MOD_RND;
            cmd.mod_by_ties = 1'b1;
            ties_next       = 1'b1;
            state_next      = ST_MOD;
          end else begin
            state_next = ST_CHKW;
          end
        end
      end
      ST_CHKW: begin
        if (sts.chosen_worst) begin
          cmd.mod_start   = 1'b1;
          cmd.mod_src     = mhs_pkg::MOD_RND_SHR;
          cmd.mod_by_ties = 1'b1;
          ties_next       = 1'b1;
          phase2_next     = 1'b1;
          state_next      = ST_MOD;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      ties   <= 1'b0;
      phase2 <= 1'b0;
      found  <= 1'b0;
    end else begin
      state  <= state_next;
      ties   <= ties_next;
      phase2 <= phase2_next;
      found  <= found_next;
    end
  end

  `ASSERT_CLK(a_update_no_busy, clk, rst, (state == ST_IDLE && in_valid && command) |=> (state == ST_IDLE))
  `ASSERT_CLK(a_out_slot_free, clk, rst, cmd.out_load |-> sts.out_free)
  `ASSERT_CLK(a_empty_fast, clk, rst, (state == ST_START && sts.n_zero) |=> (state == ST_DONE && !found))
  `ASSERT_ALWAYS(a_one_start, clk, rst, $countones({cmd.hash_start, cmd.mod_start, cmd.scan_start, cmd.sel_start}) <= 1)

endmodule

/* design/multipath_next_hop_selector.sv */
// Top level: equal-cost next-hop selector with queue-aware strategies.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall  command, five-tuple, mask, random, update
//   out       output     out_valid / out_stall chosen_port, route_found
//   cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Timing: an update item does not leave the idle state. A route item is shortest
// with an empty mask and longest with a hash and worst replacement: the 9-step
// hash mixer, a bit-serial modulo per modulo pass and a one-port-per-cycle scan
// over the candidate ports set its length.
// Reset: rst synchronous, clears queue counts, cursor and configuration.
// Stalls: a finished result waits in the output register; input is held off only
// while a route item is in progress or its result cannot yet be loaded.
module multipath_next_hop_selector #(
  parameter int NUM_PORTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [31:0] src_addr,
  input  logic [31:0] dst_addr,
  input  logic [7:0]  protocol,
  input  logic [15:0] src_port,
  input  logic [15:0] dst_port,
  input  logic [15:0] candidate_mask,
  input  logic [15:0] random_value,
  input  logic [3:0]  port_number,
  input  logic [31:0] queue_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  chosen_port,
  output logic        route_found,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);
  mhs_pkg::cmd_t cmd;
  mhs_pkg::sts_t sts;

  // configuration writes always land; the user must keep the block idle (unenforced)
  assign cfg_ready = 1'b1;

  mhs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command  (command),
    .sts      (sts),
    .cmd      (cmd)
  );

  mhs_datapath #(.NUM_PORTS(NUM_PORTS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .command        (command),
    .src_addr       (src_addr),
    .dst_addr       (dst_addr),
    .protocol       (protocol),
    .src_port       (src_port),
    .dst_port       (dst_port),
    .candidate_mask (candidate_mask),
    .random_value   (random_value),
    .port_number    (port_number),
    .queue_bytes    (queue_bytes),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .chosen_port    (chosen_port),
    .route_found    (route_found)
  );

endmodule
